>>> sv/tdct_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the three-detector coincidence tagger.
package tdct_pkg;

	localparam int TIME_BITS      = 48;
	localparam int CHANNEL_BITS   = 10;
	localparam int DET_BITS       = 2;
	localparam int KIND_BITS      = 3;
	localparam int WIN_BITS       = 20;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int MAX_RECORDS    = 6;
	localparam int REC_IDX_BITS   = $clog2(MAX_RECORDS);
	localparam int REC_CNT_BITS   = $clog2(MAX_RECORDS + 1);

	localparam logic [KIND_BITS-1:0] KIND_RAW     = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_TRIPLE  = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_PAIR_12 = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_PAIR_13 = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_PAIR_23 = 3'd4;

	localparam logic [DET_BITS-1:0] DET_NONE = 2'd0;
	localparam logic [DET_BITS-1:0] DET_ONE  = 2'd1;
	localparam logic [DET_BITS-1:0] DET_TWO  = 2'd2;
	localparam logic [DET_BITS-1:0] DET_THREE = 2'd3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TRIPLE_WINDOW = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PAIR_WINDOW   = 2'd1;

	localparam logic [WIN_BITS-1:0] WINDOW_RESET = 20'd500;

	typedef struct packed {
		logic [TIME_BITS-1:0]    hit_time;
		logic [DET_BITS-1:0]     det;
		logic [CHANNEL_BITS-1:0] chan;
	} entry_t;

	typedef struct packed {
		logic lt_triple;
		logic lt_pair;
		logic gt_pair;
	} gap_flags_t;

	typedef struct packed {
		logic [DET_BITS-1:0]     det;
		logic [CHANNEL_BITS-1:0] chan;
		logic [DET_BITS-1:0]     p1_det;
		logic [CHANNEL_BITS-1:0] p1_chan;
		logic [DET_BITS-1:0]     p2_det;
		logic [CHANNEL_BITS-1:0] p2_chan;
		gap_flags_t              f01;
		gap_flags_t              f12;
		gap_flags_t              f23;
	} hit_info_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]    kind;
		logic [DET_BITS-1:0]     det;
		logic [CHANNEL_BITS-1:0] chan;
	} record_t;

endpackage

>>> sv/tdct_cell.sv
`timescale 1ns / 1ps
// History cell: holds one past hit, compares its time with the hit handed in and shifts.
module tdct_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            shift_en,
	input  tdct_pkg::entry_t                entry_in,
	input  logic [tdct_pkg::WIN_BITS-1:0]   triple_window,
	input  logic [tdct_pkg::WIN_BITS-1:0]   pair_window,
	output tdct_pkg::entry_t                entry_out,
	output tdct_pkg::gap_flags_t            flags
);

	tdct_pkg::entry_t                 entry_q;
	logic [tdct_pkg::TIME_BITS-1:0]   gap;
	logic [tdct_pkg::TIME_BITS-1:0]   tri_win_ext;
	logic [tdct_pkg::TIME_BITS-1:0]   pair_win_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.hit_time <= '0;
			entry_q.det      <= tdct_pkg::DET_ONE;
			entry_q.chan     <= '0;
		end else if (shift_en) begin
			entry_q <= entry_in;
		end
	end

	always_comb begin
		tri_win_ext  = tdct_pkg::TIME_BITS'(triple_window);
		pair_win_ext = tdct_pkg::TIME_BITS'(pair_window);
		if (entry_in.hit_time > entry_q.hit_time) begin
			gap = entry_in.hit_time - entry_q.hit_time;
		end else begin
			gap = entry_q.hit_time - entry_in.hit_time;
		end
		flags.lt_triple = gap < tri_win_ext;
		flags.lt_pair   = gap < pair_win_ext;
		flags.gt_pair   = gap > pair_win_ext;
	end

	assign entry_out = entry_q;

endmodule

>>> sv/tdct_emit.sv
`timescale 1ns / 1ps
// Record builder/emitter: emits a classified hit's records, one per cycle unless stalled.
module tdct_emit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s1_valid,
	input  tdct_pkg::hit_info_t                 s1_info,
	output logic                                s1_take,
	output logic                                record_valid,
	input  logic                                record_stall,
	output tdct_pkg::record_t                   record,
	output logic                                record_last
);

	tdct_pkg::record_t                      list_q [tdct_pkg::MAX_RECORDS];
	logic [tdct_pkg::REC_CNT_BITS-1:0]      cnt_q;
	logic [tdct_pkg::REC_IDX_BITS-1:0]      idx_q;
	logic                                   busy_q;
	logic                                   out_valid_q;
	tdct_pkg::record_t                      out_rec_q;
	logic                                   out_last_q;

	tdct_pkg::record_t                      new_list [tdct_pkg::MAX_RECORDS];
	logic [tdct_pkg::REC_CNT_BITS-1:0]      new_cnt;
	logic                                   is_raw;
	logic                                   is_triple;
	logic                                   is_pair;
	logic                                   out_free;
	logic                                   emit;
	logic                                   at_end;
	logic                                   list_free;
	logic [tdct_pkg::DET_BITS-1:0]          lo_det;
	logic [tdct_pkg::DET_BITS-1:0]          hi_det;
	logic [tdct_pkg::CHANNEL_BITS-1:0]      lo_chan;
	logic [tdct_pkg::CHANNEL_BITS-1:0]      hi_chan;
	logic [tdct_pkg::KIND_BITS-1:0]         pair_kind;
	logic [tdct_pkg::DET_BITS-1:0]          tdet;
	logic [tdct_pkg::CHANNEL_BITS-1:0]      tchan;

	always_comb begin
		is_raw = s1_info.det != tdct_pkg::DET_NONE;
		is_triple = is_raw && s1_info.p1_det != tdct_pkg::DET_NONE
			&& s1_info.p2_det != tdct_pkg::DET_NONE
			&& s1_info.det != s1_info.p1_det && s1_info.det != s1_info.p2_det
			&& s1_info.p1_det != s1_info.p2_det
			&& s1_info.f01.lt_triple && s1_info.f12.lt_triple;
		is_pair = s1_info.f01.gt_pair && s1_info.f12.lt_pair && s1_info.f23.gt_pair
			&& s1_info.p1_det != tdct_pkg::DET_NONE
			&& s1_info.p2_det != tdct_pkg::DET_NONE
			&& s1_info.p1_det != s1_info.p2_det;

		if (s1_info.p1_det < s1_info.p2_det) begin
			lo_det  = s1_info.p1_det;
			lo_chan = s1_info.p1_chan;
			hi_det  = s1_info.p2_det;
			hi_chan = s1_info.p2_chan;
		end else begin
			lo_det  = s1_info.p2_det;
			lo_chan = s1_info.p2_chan;
			hi_det  = s1_info.p1_det;
			hi_chan = s1_info.p1_chan;
		end
		if (lo_det == tdct_pkg::DET_ONE) begin
			pair_kind = (hi_det == tdct_pkg::DET_TWO) ? tdct_pkg::KIND_PAIR_12
				: tdct_pkg::KIND_PAIR_13;
		end else begin
			pair_kind = tdct_pkg::KIND_PAIR_23;
		end

		for (int i = 0; i < tdct_pkg::MAX_RECORDS; i++) begin
			new_list[i] = '0;
		end
		new_cnt = '0;
		tdet  = '0;
		tchan = '0;
		if (is_raw) begin
			new_list[0] = '{kind: tdct_pkg::KIND_RAW, det: s1_info.det, chan: s1_info.chan};
			new_cnt = tdct_pkg::REC_CNT_BITS'(1);
		end
		if (is_triple) begin
			for (int j = 1; j <= 3; j++) begin
				tdet = tdct_pkg::DET_BITS'(j);
				if (s1_info.det == tdet) begin
					tchan = s1_info.chan;
				end else if (s1_info.p1_det == tdet) begin
					tchan = s1_info.p1_chan;
				end else begin
					tchan = s1_info.p2_chan;
				end
				new_list[new_cnt[tdct_pkg::REC_IDX_BITS-1:0]] =
					'{kind: tdct_pkg::KIND_TRIPLE, det: tdet, chan: tchan};
				new_cnt = new_cnt + tdct_pkg::REC_CNT_BITS'(1);
			end
		end
		if (is_pair) begin
			new_list[new_cnt[tdct_pkg::REC_IDX_BITS-1:0]] =
				'{kind: pair_kind, det: lo_det, chan: lo_chan};
			new_cnt = new_cnt + tdct_pkg::REC_CNT_BITS'(1);
			new_list[new_cnt[tdct_pkg::REC_IDX_BITS-1:0]] =
				'{kind: pair_kind, det: hi_det, chan: hi_chan};
			new_cnt = new_cnt + tdct_pkg::REC_CNT_BITS'(1);
		end
	end

	assign out_free  = !out_valid_q || !record_stall;
	assign emit      = busy_q && out_free;
	assign at_end    = tdct_pkg::REC_CNT_BITS'(idx_q) == cnt_q - tdct_pkg::REC_CNT_BITS'(1);
	assign list_free = !busy_q || (emit && at_end);
	assign s1_take   = s1_valid && list_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (s1_take) begin
			busy_q <= new_cnt != '0;
			cnt_q  <= new_cnt;
			idx_q  <= '0;
		end else if (emit) begin
			idx_q <= idx_q + tdct_pkg::REC_IDX_BITS'(1);
			if (at_end) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			for (int i = 0; i < tdct_pkg::MAX_RECORDS; i++) begin
				list_q[i] <= new_list[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!record_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_rec_q  <= list_q[idx_q];
			out_last_q <= at_end;
		end
	end

	assign record_valid = out_valid_q;
	assign record       = out_rec_q;
	assign record_last  = out_last_q;

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (tdct_pkg::REC_CNT_BITS'(idx_q) < cnt_q))
		else $error("record index beyond record count");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !at_end && !s1_take) |=>
			(busy_q && idx_q == $past(idx_q) + tdct_pkg::REC_IDX_BITS'(1)))
		else $error("emitter did not advance to the next record");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take |=> (idx_q == '0))
		else $error("new record list did not start at its first entry");
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !record_stall) |=> !record_valid)
		else $error("record shown without a pending list");
`endif

endmodule

>>> sv/three_detector_coincidence_tagger_unit.sv
`timescale 1ns / 1ps
// Top level of the three-detector coincidence tagger.
// Usage: hits enter on the hit channel (hit_valid, hit_stall) with a timestamp,
// a detector number and a pulse channel, in time order. Each hit on a detector other
// than zero gives a raw record, plus three triple records and/or two pair records when
// the coincidence tests pass. Records leave on the record channel (record_valid,
// record_stall), one per cycle, with last_record marking the final record of each hit;
// a hit on detector zero may give no record at all.
// A hit is registered with its gap flags in the classified-hit stage, then loaded into
// the emitter's record list, from which each record is registered onto the output.
// Throughput: one record per cycle from the single emitter; a raw-only hit frees the
// emitter as its record goes out, so such hits stream back to back, while a hit with k
// records holds the emitter until its last record goes out. A three-cell history chain
// shifts on every hit. When the receiver stalls, the shown record holds, the emitter
// pauses and hit_stall rises once the classified-hit stage behind it is full.
// Reset clears the history to time 0 on detector 1, sets both windows to 500 ns and
// empties the pipeline. The window registers are written through cfg_valid/cfg_ready,
// which is always ready; writes to other indexes are ignored.
module three_detector_coincidence_tagger_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    hit_valid,
	output logic                                    hit_stall,
	input  logic [tdct_pkg::TIME_BITS-1:0]          hit_time_ns,
	input  logic [tdct_pkg::DET_BITS-1:0]           detector_id,
	input  logic [tdct_pkg::CHANNEL_BITS-1:0]       pulse_channel,
	output logic                                    record_valid,
	input  logic                                    record_stall,
	output logic [tdct_pkg::KIND_BITS-1:0]          record_kind,
	output logic [tdct_pkg::DET_BITS-1:0]           record_detector,
	output logic [tdct_pkg::CHANNEL_BITS-1:0]       record_channel,
	output logic                                    last_record,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tdct_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [tdct_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	logic [tdct_pkg::WIN_BITS-1:0]  triple_window_q;
	logic [tdct_pkg::WIN_BITS-1:0]  pair_window_q;
	logic                           accept;
	logic                           s1_take;
	logic                           s1_valid_s1;
	tdct_pkg::hit_info_t            info_s1;
	tdct_pkg::entry_t               chain [4];
	tdct_pkg::gap_flags_t           flags [3];
	tdct_pkg::record_t              rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			triple_window_q <= tdct_pkg::WINDOW_RESET;
			pair_window_q   <= tdct_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tdct_pkg::REG_TRIPLE_WINDOW: begin
					triple_window_q <= cfg_data[tdct_pkg::WIN_BITS-1:0];
				end
				tdct_pkg::REG_PAIR_WINDOW: begin
					pair_window_q <= cfg_data[tdct_pkg::WIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign hit_stall = s1_valid_s1 && !s1_take;
	assign accept    = hit_valid && !hit_stall;

	assign chain[0].hit_time = hit_time_ns;
	assign chain[0].det      = detector_id;
	assign chain[0].chan     = pulse_channel;

	for (genvar g = 0; g < 3; g++) begin : g_cell
		tdct_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.shift_en      (accept),
			.entry_in      (chain[g]),
			.triple_window (triple_window_q),
			.pair_window   (pair_window_q),
			.entry_out     (chain[g+1]),
			.flags         (flags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_take) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1.det     <= detector_id;
			info_s1.chan    <= pulse_channel;
			info_s1.p1_det  <= chain[1].det;
			info_s1.p1_chan <= chain[1].chan;
			info_s1.p2_det  <= chain[2].det;
			info_s1.p2_chan <= chain[2].chan;
			info_s1.f01     <= flags[0];
			info_s1.f12     <= flags[1];
			info_s1.f23     <= flags[2];
		end
	end

	tdct_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid_s1),
		.s1_info      (info_s1),
		.s1_take      (s1_take),
		.record_valid (record_valid),
		.record_stall (record_stall),
		.record       (rec),
		.record_last  (last_record)
	);

	assign record_kind     = rec.kind;
	assign record_detector = rec.det;
	assign record_channel  = rec.chan;

`ifndef NO_ASSERTIONS
	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_s1) |-> s1_take)
		else $error("item accepted over a full classified-hit stage");
	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (chain[1].hit_time == $past(hit_time_ns)
			&& chain[2].hit_time == $past(chain[1].hit_time)))
		else $error("history chain did not shift with the accepted item");
	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take |-> s1_valid_s1)
		else $error("emitter took an empty stage");
`endif

endmodule
